FILE: rtl/assert_macros.svh
// Assertion macros shared by the planner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SBRP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SBRP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/sbrp_pkg.sv
// Shared types and constants for the stepper burst ramp planner.
package sbrp_pkg;

    localparam int PERIOD_W = 24;
    localparam int DUTY_W   = 9;
    localparam int THR_W    = 16;
    localparam int LVL_W    = 6;
    localparam int RST_W    = 16;
    localparam int PULSE_W  = 16;
    localparam int REM_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Divider: quotient bits resolved per cycle and resulting iteration count.
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITER  = PERIOD_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    localparam logic [PERIOD_W-1:0] FULL_PERIOD_RST    = 24'd100000;
    localparam logic [DUTY_W-1:0]   DUTY_RST           = 9'd128;
    localparam logic [DUTY_W-1:0]   DUTY_ONE           = 9'd256;
    localparam logic [THR_W-1:0]    RAMP_THRESHOLD_RST = 16'd45;
    localparam logic [LVL_W-1:0]    MAX_LEVEL_RST      = 6'd10;
    localparam logic [RST_W-1:0]    RESTART_REMAIN_RST = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_PERIOD    = 3'd0,
        REG_DUTY_Q8        = 3'd1,
        REG_RAMP_THRESHOLD = 3'd2,
        REG_MAX_LEVEL      = 3'd3,
        REG_RESTART_REMAIN = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend;
        logic [LVL_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/sbrp_div.sv
// Iterative restoring divider: base period by speed level, a few bits per cycle.
`include "assert_macros.svh"

module sbrp_div
    import sbrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PERIOD_W-1:0]  quo_reg, quo_next;
    logic [LVL_W-1:0]     part_reg, part_next;
    logic [LVL_W-1:0]     dsr_reg, dsr_next;

    always_comb begin
        logic [LVL_W:0]      t;
        logic [LVL_W-1:0]    r;
        logic [PERIOD_W-1:0] q;
        r = part_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            // shift next dividend bit into the partial remainder
            t = {r, q[PERIOD_W-1]};
            q = {q[PERIOD_W-2:0], 1'b0};
            if (t >= {1'b0, dsr_reg}) begin
                t    = t - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = t[LVL_W-1:0];
        end

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        part_next = part_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            run_next  = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_ITER - 1);
            quo_next  = req.dividend;
            part_next = '0;
            dsr_next  = req.divisor;
        end else if (run_reg) begin
            quo_next  = q;
            part_next = r;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        part_reg <= part_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `SBRP_ASSERT_NOW(a_no_restart, aclk, aresetn, req.start, !run_reg)
    `SBRP_ASSERT_NOW(a_part_below_dsr, aclk, aresetn, run_reg, part_reg < dsr_reg)
    `SBRP_ASSERT_NOW(a_done_after_run, aclk, aresetn, done_reg, !run_reg)

endmodule

FILE: rtl/stepper_burst_ramp_planner.sv
// Stepper burst ramp planner: ramp sequencer, config registers and result register.
// Burst-done beats and non-launching moves: ST_OUT loads the result register once it is free.
// Launching moves: ST_DIV over the divider's two-bit iterations, then ST_MUL registers the
// quotient and its duty-scaled product, then ST_OUT loads the result register.
// Beats are taken only in ST_IDLE, after the last result is loaded, even while it waits.
// Synchronous active-low reset clears ramp state and restores register defaults.
`include "assert_macros.svh"

module stepper_burst_ramp_planner
    import sbrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [PULSE_W-1:0]   s_move_pulses,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_start_burst,
    output logic                 m_stop_burst,
    output logic [LVL_W-1:0]     m_burst_pulses,
    output logic [PERIOD_W-1:0]  m_period_ticks,
    output logic [PERIOD_W-1:0]  m_high_ticks
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    localparam logic [REM_W-1:0] REM_MAX = {1'b0, {(REM_W-1){1'b1}}};
    localparam logic [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

    function automatic logic [REM_W-1:0] sat_rem(input logic [REM_W:0] v);
        logic [REM_W-1:0] r;
        r = v[REM_W-1:0];
        if (v[REM_W] != v[REM_W-1]) begin
            r = v[REM_W] ? REM_MIN : REM_MAX;
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [PERIOD_W-1:0] full_period_reg;
    logic [DUTY_W-1:0]   duty_q8_reg;
    logic [THR_W-1:0]    ramp_threshold_reg;
    logic [LVL_W-1:0]    max_level_reg;
    logic [RST_W-1:0]    restart_remain_reg;

    logic [REM_W-1:0] remainder_reg, remainder_next;
    logic [LVL_W-1:0] level_now_reg, level_now_next;
    logic [LVL_W-1:0] level_pending_reg, level_pending_next;
    logic             busy_reg, busy_next;

    logic                res_start_reg, res_start_next;
    logic                res_stop_reg, res_stop_next;
    logic [LVL_W-1:0]    res_count_reg, res_count_next;
    logic [PERIOD_W-1:0] res_period_reg, res_period_next;
    logic [PERIOD_W-1:0] res_high_reg, res_high_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_start_reg, m_start_next;
    logic                m_stop_reg, m_stop_next;
    logic [LVL_W-1:0]    m_count_reg, m_count_next;
    logic [PERIOD_W-1:0] m_period_reg, m_period_next;
    logic [PERIOD_W-1:0] m_high_reg, m_high_next;

    logic [REM_W-1:0] rem_add, rem_ramp, rem_launch;
    logic [LVL_W-1:0] pend_ramp, now_ramp;
    logic             launch, accept;
    logic [DUTY_W-1:0] duty_eff;
    logic [PERIOD_W+DUTY_W-1:0] product;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sbrp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_period_reg    <= FULL_PERIOD_RST;
            duty_q8_reg        <= DUTY_RST;
            ramp_threshold_reg <= RAMP_THRESHOLD_RST;
            max_level_reg      <= MAX_LEVEL_RST;
            restart_remain_reg <= RESTART_REMAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FULL_PERIOD:    full_period_reg    <= cfg_wdata;
                REG_DUTY_Q8:        duty_q8_reg        <= cfg_wdata[DUTY_W-1:0];
                REG_RAMP_THRESHOLD: ramp_threshold_reg <= cfg_wdata[THR_W-1:0];
                REG_MAX_LEVEL:      max_level_reg      <= cfg_wdata[LVL_W-1:0];
                REG_RESTART_REMAIN: restart_remain_reg <= cfg_wdata[RST_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // ramp decision for a move beat
    always_comb begin
        rem_add   = sat_rem({remainder_reg[REM_W-1], remainder_reg}
                            + {{(REM_W-PULSE_W+1){1'b0}}, s_move_pulses});
        rem_ramp  = rem_add;
        pend_ramp = level_pending_reg;
        now_ramp  = level_now_reg;
        if (level_pending_reg == '0) begin
            if ($signed(rem_add) > $signed({{(REM_W-THR_W){1'b0}}, ramp_threshold_reg})) begin
                pend_ramp = (level_now_reg < max_level_reg) ? level_now_reg + 1'b1
                                                            : max_level_reg;
            end else begin
                if (level_now_reg != '0) begin
                    pend_ramp = level_now_reg - 1'b1;
                end
                // ramp bottomed out: reload the remainder
                if (pend_ramp == '0) begin
                    now_ramp = '0;
                    rem_ramp = {{(REM_W-RST_W){1'b0}}, restart_remain_reg};
                end
            end
        end
        launch     = !busy_reg && (pend_ramp != '0);
        rem_launch = sat_rem({rem_ramp[REM_W-1], rem_ramp}
                             - {{(REM_W-LVL_W+1){1'b0}}, pend_ramp});
    end

    assign duty_eff = (duty_q8_reg > DUTY_ONE) ? DUTY_ONE : duty_q8_reg;
    assign product  = div_rsp.quotient * duty_eff;

    assign div_req.start    = accept && !s_req_type && launch;
    assign div_req.dividend = full_period_reg;
    assign div_req.divisor  = pend_ramp;

    always_comb begin
        state_next         = state_reg;
        remainder_next     = remainder_reg;
        level_now_next     = level_now_reg;
        level_pending_next = level_pending_reg;
        busy_next          = busy_reg;
        res_start_next     = res_start_reg;
        res_stop_next      = res_stop_reg;
        res_count_next     = res_count_reg;
        res_period_next    = res_period_reg;
        res_high_next      = res_high_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_start_next       = m_start_reg;
        m_stop_next        = m_stop_reg;
        m_count_next       = m_count_reg;
        m_period_next      = m_period_reg;
        m_high_next        = m_high_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_period_next = '0;
                    res_high_next   = '0;
                    if (s_req_type) begin
                        busy_next      = 1'b0;
                        res_start_next = 1'b0;
                        res_stop_next  = 1'b1;
                        res_count_next = '0;
                        state_next     = ST_OUT;
                    end else begin
                        res_stop_next  = 1'b0;
                        res_start_next = launch;
                        if (launch) begin
                            remainder_next     = rem_launch;
                            level_now_next     = pend_ramp;
                            level_pending_next = '0;
                            busy_next          = 1'b1;
                            res_count_next     = pend_ramp;
                            state_next         = ST_DIV;
                        end else begin
                            remainder_next     = rem_ramp;
                            level_now_next     = now_ramp;
                            level_pending_next = pend_ramp;
                            res_count_next     = '0;
                            state_next         = ST_OUT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                res_period_next = div_rsp.quotient;
                res_high_next   = product[PERIOD_W+7:8];
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_start_next  = res_start_reg;
                    m_stop_next   = res_stop_reg;
                    m_count_next  = res_count_reg;
                    m_period_next = res_period_reg;
                    m_high_next   = res_high_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            remainder_reg     <= '0;
            level_now_reg     <= '0;
            level_pending_reg <= '0;
            busy_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            remainder_reg     <= remainder_next;
            level_now_reg     <= level_now_next;
            level_pending_reg <= level_pending_next;
            busy_reg          <= busy_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_start_reg  <= res_start_next;
        res_stop_reg   <= res_stop_next;
        res_count_reg  <= res_count_next;
        res_period_reg <= res_period_next;
        res_high_reg   <= res_high_next;
        m_start_reg    <= m_start_next;
        m_stop_reg     <= m_stop_next;
        m_count_reg    <= m_count_next;
        m_period_reg   <= m_period_next;
        m_high_reg     <= m_high_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_start_burst  = m_start_reg;
    assign m_stop_burst   = m_stop_reg;
    assign m_burst_pulses = m_count_reg;
    assign m_period_ticks = m_period_reg;
    assign m_high_ticks   = m_high_reg;

    `SBRP_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, accept, !s_ready)
    `SBRP_ASSERT_NOW(a_start_has_pulses, aclk, aresetn, m_valid && m_start_burst,
        m_burst_pulses != '0)
    `SBRP_ASSERT_NOW(a_start_xor_stop, aclk, aresetn, m_valid,
        !(m_start_burst && m_stop_burst))
    `SBRP_ASSERT_NOW(a_high_within_period, aclk, aresetn, m_valid,
        m_high_ticks <= m_period_ticks)
    `SBRP_ASSERT_NOW(a_div_only_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV)

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the stepper burst ramp planner: table-driven corners, random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbrp_pkg::*;

    localparam bit REQ_MOVE = 1'b0;
    localparam bit REQ_DONE = 1'b1;

    localparam int QUIET_LIMIT  = 4000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 165;
    localparam int SAT_MOVES    = 40;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_REPORTS  = 40;

    localparam longint REM_MAX = 64'sd2147483647;
    localparam longint REM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                start;
        logic                stop;
        logic [LVL_W-1:0]    pulses;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] high;
    } burst_plan_t;

    typedef enum logic [1:0] {ROW_SEND, ROW_CHECK, ROW_WRITE} row_kind_e;
    typedef enum logic [1:0] {PICK_LOW, PICK_HIGH, PICK_MILD, PICK_ANY} pick_e;

    typedef struct packed {
        row_kind_e           kind;
        logic                req;
        logic [PULSE_W-1:0]  pulses;
        cfg_reg_t            reg_idx;
        logic [PERIOD_W-1:0] wval;
        burst_plan_t         want;
    } plan_row_t;

    localparam burst_plan_t NO_BURST  = '0;
    localparam burst_plan_t STOP_ONLY = {1'b0, 1'b1, 6'd0, 24'd0, 24'd0};

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [PERIOD_W-1:0]  cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_req_type    = 1'b0;
    logic [PULSE_W-1:0]   s_move_pulses = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_start_burst;
    logic                 m_stop_burst;
    logic [LVL_W-1:0]     m_burst_pulses;
    logic [PERIOD_W-1:0]  m_period_ticks;
    logic [PERIOD_W-1:0]  m_high_ticks;

    // Planner state and register copies, as they stand after reset.
    int                  rem_now  = 0;
    logic [LVL_W-1:0]    lvl_now  = '0;
    logic [LVL_W-1:0]    lvl_pend = '0;
    bit                  run_busy = 1'b0;
    logic [PERIOD_W-1:0] cfg_full_period = FULL_PERIOD_RST;
    logic [DUTY_W-1:0]   cfg_duty        = DUTY_RST;
    logic [THR_W-1:0]    cfg_thr         = RAMP_THRESHOLD_RST;
    logic [LVL_W-1:0]    cfg_max         = MAX_LEVEL_RST;
    logic [RST_W-1:0]    cfg_restart     = RESTART_REMAIN_RST;

    burst_plan_t plans_due[$];
    plan_row_t   directed_rows[$];

    int fail_count   = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit ready_pinned = 1'b0;
    bit calm         = 1'b0;

    stepper_burst_ramp_planner dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_move_pulses  (s_move_pulses),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_start_burst  (m_start_burst),
        .m_stop_burst   (m_stop_burst),
        .m_burst_pulses (m_burst_pulses),
        .m_period_ticks (m_period_ticks),
        .m_high_ticks   (m_high_ticks)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int clamp_rem(longint v);
        if (v > REM_MAX) return int'(REM_MAX);
        if (v < REM_MIN) return int'(REM_MIN);
        return int'(v);
    endfunction

    function automatic burst_plan_t plan_step(logic req, logic [PULSE_W-1:0] pulses);
        burst_plan_t       plan;
        logic [DUTY_W-1:0] duty;
        logic [63:0]       prod;
        plan = '0;
        if (req == REQ_DONE) begin
            plan.stop = 1'b1;
            run_busy = 1'b0;
        end else begin
            rem_now = clamp_rem(longint'(rem_now) + longint'(pulses));
            if (lvl_pend == '0) begin
                if (longint'(rem_now) > longint'(cfg_thr)) begin
                    lvl_pend = (lvl_now < cfg_max) ? lvl_now + 1'b1 : cfg_max;
                end else begin
                    if (lvl_now != '0)
                        lvl_pend = lvl_now - 1'b1;
                    // bottom of the ramp: drop the level and reload the remainder
                    if (lvl_pend == '0) begin
                        lvl_now = '0;
                        rem_now = int'(cfg_restart);
                    end
                end
            end
            if (!run_busy && lvl_pend != '0) begin
                duty = (cfg_duty > DUTY_ONE) ? DUTY_ONE : cfg_duty;
                lvl_now = lvl_pend;
                lvl_pend = '0;
                plan.start = 1'b1;
                plan.pulses = lvl_now;
                plan.period = cfg_full_period / lvl_now;
                prod = {40'd0, plan.period} * {55'd0, duty};
                plan.high = prod[PERIOD_W+7:8];
                rem_now = clamp_rem(longint'(rem_now) - longint'(lvl_now));
                run_busy = 1'b1;
            end
        end
        return plan;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PERIOD_W-1:0] cfg_value(cfg_reg_t idx, pick_e pick);
        logic [PERIOD_W-1:0] v;
        v = '0;
        case (idx)
            REG_FULL_PERIOD: begin
                case (pick)
                    PICK_LOW:  v = 24'd1;
                    PICK_HIGH: v = 24'hFFFFFF;
                    PICK_MILD: v = PERIOD_W'($urandom_range(1, 5000));
                    default:   v = PERIOD_W'($urandom_range(0, 24'hFFFFFF));
                endcase
            end
            REG_DUTY_Q8: begin
                case (pick)
                    PICK_LOW:  v = 24'd0;
                    PICK_HIGH: v = 24'd511;
                    PICK_MILD: v = PERIOD_W'($urandom_range(0, 256));
                    default:   v = PERIOD_W'($urandom_range(0, 511));
                endcase
            end
            REG_RAMP_THRESHOLD: begin
                case (pick)
                    PICK_LOW:  v = 24'd0;
                    PICK_HIGH: v = 24'd65535;
                    PICK_MILD: v = PERIOD_W'($urandom_range(0, 100));
                    default:   v = PERIOD_W'($urandom_range(0, 65535));
                endcase
            end
            REG_MAX_LEVEL: begin
                case (pick)
                    PICK_LOW:  v = 24'd1;
                    PICK_HIGH: v = 24'd63;
                    PICK_MILD: v = PERIOD_W'($urandom_range(1, 8));
                    default:   v = PERIOD_W'($urandom_range(0, 63));
                endcase
            end
            REG_RESTART_REMAIN: begin
                case (pick)
                    PICK_LOW:  v = 24'd0;
                    PICK_HIGH: v = 24'd65535;
                    PICK_MILD: v = PERIOD_W'($urandom_range(0, 300));
                    default:   v = PERIOD_W'($urandom_range(0, 65535));
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (fail_count < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void sched_send(logic req, logic [PULSE_W-1:0] pulses);
        plan_row_t row;
        row = '0;
        row.kind = ROW_SEND;
        row.req = req;
        row.pulses = pulses;
        directed_rows.push_back(row);
    endfunction

    function automatic void sched_check(logic req, logic [PULSE_W-1:0] pulses, burst_plan_t want);
        plan_row_t row;
        row = '0;
        row.kind = ROW_CHECK;
        row.req = req;
        row.pulses = pulses;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void sched_write(cfg_reg_t idx, logic [PERIOD_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.wval = val;
        directed_rows.push_back(row);
    endfunction

    // Present one beat, hold it until taken, then log what it should produce.
    task automatic send_item(logic req, logic [PULSE_W-1:0] pulses, int gap, bit typed,
                             burst_plan_t want);
        burst_plan_t plan;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_move_pulses <= pulses;
        do @(posedge aclk); while (!s_ready);
        plan = plan_step(req, pulses);
        plans_due.push_back(typed ? want : plan);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (plans_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [PERIOD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_FULL_PERIOD:    cfg_full_period = val;
            REG_DUTY_Q8:        cfg_duty = val[DUTY_W-1:0];
            REG_RAMP_THRESHOLD: cfg_thr = val[THR_W-1:0];
            REG_MAX_LEVEL:      cfg_max = val[LVL_W-1:0];
            REG_RESTART_REMAIN: cfg_restart = val[RST_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_side
        burst_plan_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                if (plans_due.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $error("result beat with no expected plan pending");
                    fail_count++;
                end else begin
                    want = plans_due.pop_front();
                    compare_field("start_burst", 32'(want.start), 32'(m_start_burst));
                    compare_field("stop_burst", 32'(want.stop), 32'(m_stop_burst));
                    compare_field("burst_pulses", 32'(want.pulses), 32'(m_burst_pulses));
                    compare_field("period_ticks", 32'(want.period), 32'(m_period_ticks));
                    compare_field("high_ticks", 32'(want.high), 32'(m_high_ticks));
                end
            end
            // flip between stretches with and without stalls on both sides
            if ($urandom_range(0, 299) == 0)
                calm = !calm;
            if (ready_pinned || calm) begin
                m_ready <= 1'b1;
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pause_len();
            end
        end
    end

    initial begin
        wait (aresetn === 1'b1);
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("[stepper_burst_ramp_planner] ERROR");
        $finish;
    end

    initial begin
        cfg_reg_t    r;
        logic        req;
        logic [PULSE_W-1:0] pulses;
        pick_e       pick;

        // Corners from reset values, then one register at a time.
        sched_check(REQ_DONE, 16'hFFFF, STOP_ONLY);
        sched_check(REQ_MOVE, 16'd100, {1'b1, 1'b0, 6'd1, 24'd100000, 24'd50000});
        sched_check(REQ_MOVE, 16'd0, NO_BURST);
        sched_check(REQ_DONE, 16'd0, STOP_ONLY);
        sched_check(REQ_MOVE, 16'd0, {1'b1, 1'b0, 6'd2, 24'd50000, 24'd25000});
        sched_send(REQ_DONE, 16'h5A5A);
        sched_write(REG_DUTY_Q8, 24'd511);
        sched_send(REQ_MOVE, 16'd0);
        sched_send(REQ_DONE, 16'd0);
        sched_write(REG_FULL_PERIOD, 24'd0);
        sched_check(REQ_MOVE, 16'd0, {1'b1, 1'b0, 6'd4, 24'd0, 24'd0});
        sched_send(REQ_DONE, 16'd0);
        sched_write(REG_FULL_PERIOD, 24'hFFFFFF);
        sched_write(REG_DUTY_Q8, 24'd0);
        sched_send(REQ_MOVE, 16'd0);
        sched_send(REQ_DONE, 16'd0);
        // level above the new maximum clamps to it
        sched_write(REG_MAX_LEVEL, 24'd2);
        sched_send(REQ_MOVE, 16'd0);
        sched_send(REQ_DONE, 16'd0);
        sched_write(REG_MAX_LEVEL, 24'd0);
        sched_check(REQ_MOVE, 16'd0, NO_BURST);
        // ramp down to zero and reload the remainder
        sched_write(REG_MAX_LEVEL, 24'd63);
        sched_write(REG_RAMP_THRESHOLD, 24'd65535);
        sched_write(REG_RESTART_REMAIN, 24'd65535);
        sched_send(REQ_MOVE, 16'd0);
        sched_send(REQ_DONE, 16'd0);
        sched_send(REQ_MOVE, 16'd0);
        sched_write(REG_RAMP_THRESHOLD, 24'd0);
        sched_write(REG_RESTART_REMAIN, 24'd0);
        sched_send(REQ_MOVE, 16'd1);
        sched_send(REQ_DONE, 16'd0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WRITE: begin
                    wait_drained();
                    write_reg(directed_rows[i].reg_idx, directed_rows[i].wval);
                end
                ROW_CHECK: send_item(directed_rows[i].req, directed_rows[i].pulses,
                                     pause_len(), 1'b1, directed_rows[i].want);
                default:   send_item(directed_rows[i].req, directed_rows[i].pulses,
                                     pause_len(), 1'b0, NO_BURST);
            endcase
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            r = r.first();
            repeat (r.num()) begin
                if (phase == 0)
                    pick = PICK_LOW;
                else if (phase == 1)
                    pick = PICK_HIGH;
                else
                    pick = pick_e'($urandom_range(0, 3));
                write_reg(r, cfg_value(r, pick));
                r = r.next();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mostly move / burst-done pairs, with stray beats mixed in
                if (run_busy)
                    req = ($urandom_range(0, 99) < 80) ? REQ_DONE : REQ_MOVE;
                else
                    req = ($urandom_range(0, 99) < 10) ? REQ_DONE : REQ_MOVE;
                if (req == REQ_DONE) begin
                    pulses = PULSE_W'($urandom_range(0, 65535));
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8: pulses = 16'd0;
                        9, 10, 11, 12, 13, 14:     pulses = PULSE_W'($urandom_range(1, 16));
                        15, 16, 17, 18:            pulses = PULSE_W'($urandom_range(17, 1000));
                        default:                   pulses = PULSE_W'($urandom_range(0, 65535));
                    endcase
                end
                send_item(req, pulses, calm ? 0 : pause_len(), 1'b0, NO_BURST);
            end
        end

        // Hold a burst open and pile on full moves back to back.
        wait_drained();
        write_reg(REG_MAX_LEVEL, 24'd63);
        ready_pinned = 1'b1;
        repeat (SAT_MOVES) send_item(REQ_MOVE, 16'hFFFF, 0, 1'b0, NO_BURST);
        ready_pinned = 1'b0;
        repeat (3) begin
            send_item(REQ_DONE, 16'd0, pause_len(), 1'b0, NO_BURST);
            send_item(REQ_MOVE, 16'hFFFF, pause_len(), 1'b0, NO_BURST);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[stepper_burst_ramp_planner] OK");
        else
            $display("[stepper_burst_ramp_planner] ERROR");
        $finish;
    end

endmodule
